>>> rtl/imp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imp_pkg: shared types and constants of the inertial motion profile
// Beat layouts, command codes, register indexes, reset values and the
// control and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package imp_pkg;

    localparam int unsigned CfgWidth = 31;

    // Command codes of the cmd field.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_JUMP = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ACCEL     = 1'b0;
    localparam logic CFG_MAX_SPEED = 1'b1;

    localparam logic [CfgWidth-1:0] ACCEL_RESET     = 31'd65536;
    localparam logic [CfgWidth-1:0] MAX_SPEED_RESET = 31'd6553600;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        dt;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic               at_target;
    } t_out_beat;

    // Operand pairs of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_DTDT = 3'd0,
        MUL_AD   = 3'd1,
        MUL_VV   = 3'd2,
        MUL_DV   = 3'd3,
        MUL_ACC  = 3'd4,
        MUL_ND   = 3'd5
    } t_mul_op;

    typedef struct packed {
        logic    load_in;
        logic    apply;
        logic    prep;
        t_mul_op mul_op;
        logic    cap_dtdt;
        logic    cap_ad;
        logic    cap_vv;
        logic    cap_dv;
        logic    cap_vel;
        logic    cap_pos;
        logic    commit;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic at_target;
    } t_dp_stat;

endpackage

>>> rtl/imp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imp_ctrl: sequencer of the inertial motion profile
// Steps one accepted beat through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module imp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  imp_pkg::t_dp_stat  i_stat,
    output imp_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_PREP  = 11'b000_0000_0010,
        ST_M_AD  = 11'b000_0000_0100,
        ST_M_VV  = 11'b000_0000_1000,
        ST_M_DV  = 11'b000_0001_0000,
        ST_M_ACC = 11'b000_0010_0000,
        ST_VEL   = 11'b000_0100_0000,
        ST_M_ND  = 11'b000_1000_0000,
        ST_POS   = 11'b001_0000_0000,
        ST_SNAP  = 11'b010_0000_0000,
        ST_FIN   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_op  = imp_pkg::MUL_DTDT;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.apply  = 1'b1;
                o_cmd.prep   = 1'b1;
                o_cmd.mul_op = imp_pkg::MUL_DTDT;
                if (i_stat.is_tick && !i_stat.at_target) begin
                    n_state = ST_M_AD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_M_AD: begin
                o_cmd.mul_op   = imp_pkg::MUL_AD;
                o_cmd.cap_dtdt = 1'b1;
                n_state        = ST_M_VV;
            end
            ST_M_VV: begin
                o_cmd.mul_op = imp_pkg::MUL_VV;
                o_cmd.cap_ad = 1'b1;
                n_state      = ST_M_DV;
            end
            ST_M_DV: begin
                o_cmd.mul_op = imp_pkg::MUL_DV;
                o_cmd.cap_vv = 1'b1;
                n_state      = ST_M_ACC;
            end
            ST_M_ACC: begin
                o_cmd.mul_op = imp_pkg::MUL_ACC;
                o_cmd.cap_dv = 1'b1;
                n_state      = ST_VEL;
            end
            ST_VEL: begin
                o_cmd.cap_vel = 1'b1;
                n_state       = ST_M_ND;
            end
            ST_M_ND: begin
                o_cmd.mul_op = imp_pkg::MUL_ND;
                n_state      = ST_POS;
            end
            ST_POS: begin
                o_cmd.cap_pos = 1'b1;
                n_state       = ST_SNAP;
            end
            ST_SNAP: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                // Wait until the output register is free.
                if (!(r_out_valid && i_out_stall)) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/imp_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imp_dpath: datapath of the inertial motion profile
// Motion state, configuration, one shared 32x32 multiplier and the
// intermediate terms of a tick, each stage driven by the sequencer.
// ----------------------------------------------------------------------------
module imp_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  imp_pkg::t_in_beat                  i_in_data,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [imp_pkg::CfgWidth-1:0]       i_cfg_data,
    input  imp_pkg::t_dp_cmd                   i_cmd,
    output imp_pkg::t_dp_stat                  o_stat,
    output imp_pkg::t_out_beat                 o_out_data
);

    imp_pkg::t_in_beat  r_in;
    imp_pkg::t_out_beat r_out;

    logic [imp_pkg::CfgWidth-1:0] r_accel, n_accel;
    logic [imp_pkg::CfgWidth-1:0] r_max, n_max;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_tgt, n_tgt;
    logic [31:0] r_vel, n_vel;

    logic [31:0] r_dist;
    logic        r_dir_pos;
    logic [31:0] r_vmag;
    logic [63:0] r_prod;
    logic [31:0] r_dtdt;
    logic [62:0] r_ad;
    logic [63:0] r_vv;
    logic [30:0] r_dv;
    logic        r_acc_neg;
    logic [29:0] r_acc_t;
    logic [31:0] r_nv;
    logic [30:0] r_nmag;
    logic [31:0] r_np;
    logic [29:0] r_lim;

    // ------------------------------------------------------------------
    // Distance, direction and speed magnitude.
    // ------------------------------------------------------------------
    logic [32:0] w_diff;
    logic [32:0] w_dist_x;
    logic [31:0] w_vmag;
    logic        w_vel_pos;
    logic        w_vel_neg;

    assign w_diff    = {r_pos[31], r_pos} - {r_tgt[31], r_tgt};
    assign w_dist_x  = w_diff[32] ? (~w_diff + 33'd1) : w_diff;
    assign w_vmag    = r_vel[31] ? (~r_vel + 32'd1) : r_vel;
    assign w_vel_neg = r_vel[31];
    assign w_vel_pos = !r_vel[31] && (r_vel != 32'd0);

    // ------------------------------------------------------------------
    // Shared multiplier, product registered.
    // ------------------------------------------------------------------
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;

    always_comb begin
        case (i_cmd.mul_op)
            imp_pkg::MUL_DTDT: begin
                w_ma = {16'd0, r_in.dt};
                w_mb = {16'd0, r_in.dt};
            end
            imp_pkg::MUL_AD: begin
                w_ma = {1'b0, r_accel};
                w_mb = r_dist;
            end
            imp_pkg::MUL_VV: begin
                w_ma = r_vmag;
                w_mb = r_vmag;
            end
            imp_pkg::MUL_DV: begin
                w_ma = {16'd0, r_in.dt};
                w_mb = {1'b0, r_accel};
            end
            imp_pkg::MUL_ACC: begin
                w_ma = r_dtdt;
                w_mb = {1'b0, r_accel};
            end
            imp_pkg::MUL_ND: begin
                w_ma = {1'b0, r_nmag};
                w_mb = {16'd0, r_in.dt};
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end

    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};

    // ------------------------------------------------------------------
    // Brake decision: accel * dist <= floor(v * v / 2) while moving
    // toward the target.
    // ------------------------------------------------------------------
    logic w_toward;
    logic w_brake;

    assign w_toward = (w_vel_pos && r_dir_pos) || (w_vel_neg && !r_dir_pos);
    assign w_brake  = w_toward && ({1'b0, r_ad} <= {1'b0, r_vv[63:1]});

    // ------------------------------------------------------------------
    // New velocity: step, zero on reversal, clamp the magnitude.
    // ------------------------------------------------------------------
    logic [33:0] w_vel_x;
    logic [33:0] w_dv_x;
    logic [33:0] w_nv0;
    logic        w_rev;
    logic [33:0] w_nv1;
    logic [33:0] w_nmag1;
    logic        w_clamp;
    logic [31:0] w_nv;
    logic [30:0] w_nmag;

    assign w_vel_x = {{2{r_vel[31]}}, r_vel};
    assign w_dv_x  = {3'd0, r_dv};
    assign w_nv0   = r_acc_neg ? (w_vel_x - w_dv_x) : (w_vel_x + w_dv_x);
    assign w_rev   = (w_nv0[33] && w_vel_pos)
                  || (!w_nv0[33] && (w_nv0 != 34'd0) && w_vel_neg);
    assign w_nv1   = w_rev ? 34'd0 : w_nv0;
    assign w_nmag1 = w_nv1[33] ? (~w_nv1 + 34'd1) : w_nv1;
    assign w_clamp = (w_nmag1 >= {3'd0, r_max});

    always_comb begin
        if (w_clamp) begin
            w_nmag = r_max;
            if (w_nv1[33]) begin
                w_nv = ~{1'b0, r_max} + 32'd1;
            end else if (w_nv1 == 34'd0) begin
                w_nv = 32'd0;
            end else begin
                w_nv = {1'b0, r_max};
            end
        end else begin
            w_nmag = w_nmag1[30:0];
            w_nv   = w_nv1[31:0];
        end
    end

    // ------------------------------------------------------------------
    // New position: old + velocity term + acceleration term, saturated.
    // ------------------------------------------------------------------
    logic [34:0] w_pos_x;
    logic [34:0] w_t1_x;
    logic [34:0] w_t2_x;
    logic [34:0] w_np0;
    logic        w_ovf;
    logic [31:0] w_np;

    assign w_pos_x = {{3{r_pos[31]}}, r_pos};
    assign w_t1_x  = {4'd0, r_prod[46:16]};
    assign w_t2_x  = {5'd0, r_acc_t};
    assign w_np0   = w_pos_x
                   + (r_nv[31]  ? (~w_t1_x + 35'd1) : w_t1_x)
                   + (r_acc_neg ? (~w_t2_x + 35'd1) : w_t2_x);
    assign w_ovf   = (w_np0[34:31] != 4'b0000) && (w_np0[34:31] != 4'b1111);

    always_comb begin
        if (!w_ovf) begin
            w_np = w_np0[31:0];
        end else if (w_np0[34]) begin
            w_np = 32'h8000_0000;
        end else begin
            w_np = 32'h7FFF_FFFF;
        end
    end

    // ------------------------------------------------------------------
    // Snap to the target when within |v| * dt / 2 of it.
    // ------------------------------------------------------------------
    logic [32:0] w_sdiff;
    logic [32:0] w_smag;
    logic        w_snap;

    assign w_sdiff = {r_np[31], r_np} - {r_tgt[31], r_tgt};
    assign w_smag  = w_sdiff[32] ? (~w_sdiff + 33'd1) : w_sdiff;
    assign w_snap  = (w_smag <= {3'd0, r_lim});

    // ------------------------------------------------------------------
    // Architectural state and configuration.
    // ------------------------------------------------------------------
    always_comb begin
        n_accel = r_accel;
        n_max   = r_max;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                imp_pkg::CFG_ACCEL:     n_accel = i_cfg_data;
                imp_pkg::CFG_MAX_SPEED: n_max   = i_cfg_data;
                default:                n_accel = r_accel;
            endcase
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_tgt = r_tgt;
        n_vel = r_vel;
        if (i_cmd.apply) begin
            case (r_in.cmd)
                imp_pkg::CMD_SET: begin
                    n_tgt = r_in.value;
                end
                imp_pkg::CMD_JUMP: begin
                    n_pos = r_in.value;
                    n_tgt = r_in.value;
                    n_vel = 32'd0;
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
        if (i_cmd.commit) begin
            n_pos = w_snap ? r_tgt : r_np;
            n_vel = w_snap ? 32'd0 : r_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= imp_pkg::ACCEL_RESET;
            r_max   <= imp_pkg::MAX_SPEED_RESET;
            r_pos   <= 32'd0;
            r_tgt   <= 32'd0;
            r_vel   <= 32'd0;
        end else begin
            r_accel <= n_accel;
            r_max   <= n_max;
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
            r_vel   <= n_vel;
        end
    end

    // Working registers of a tick; no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.prep) begin
            r_dist    <= w_dist_x[31:0];
            r_dir_pos <= w_diff[32];
            r_vmag    <= w_vmag;
        end
        if (i_cmd.cap_dtdt) begin
            r_dtdt <= r_prod[31:0];
        end
        if (i_cmd.cap_ad) begin
            r_ad <= r_prod[62:0];
        end
        if (i_cmd.cap_vv) begin
            r_vv <= r_prod;
        end
        if (i_cmd.cap_dv) begin
            r_dv      <= r_prod[46:16];
            r_acc_neg <= w_brake ? r_dir_pos : !r_dir_pos;
        end
        if (i_cmd.cap_vel) begin
            r_acc_t <= r_prod[62:33];
            r_nv    <= w_nv;
            r_nmag  <= w_nmag;
        end
        if (i_cmd.cap_pos) begin
            r_np  <= w_np;
            r_lim <= r_prod[46:17];
        end
        if (i_cmd.load_out) begin
            r_out.position  <= r_pos;
            r_out.velocity  <= r_vel;
            r_out.at_target <= (r_pos == r_tgt);
        end
    end

    assign o_stat.is_tick   = (r_in.cmd == imp_pkg::CMD_TICK);
    assign o_stat.at_target = (r_pos == r_tgt);
    assign o_out_data       = r_out;

endmodule

>>> rtl/inertial_motion_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inertial_motion_profile: trapezoidal velocity profile generator
// Q16.16 motion generator that ticks, retargets or jumps on each beat.
// ----------------------------------------------------------------------------
// Usage. The input channel carries one command beat (cmd, dt, value) and is
// accepted when i_in_valid is high and o_in_stall is low. Every input beat
// produces exactly one output beat with the position, velocity and an
// at-target flag as they stand after the command. The output channel is
// accepted when o_out_valid is high and i_out_stall is low.
// The block works on one beat at a time. A tick away from the target steps
// from acceptance through the prep, product, velocity, position, snap and
// finish states to output valid; a set-target, jump, unused code or tick
// already at the target goes from prep straight to finish. The sequencer
// returns to idle in the cycle the result turns valid. The length of
// a tick comes from six dependent products that share one registered 32x32
// multiplier, one product per cycle, plus velocity, position and snap
// stages. The result sits in an output register, so the next beat is taken
// as soon as the sequencer returns to idle, even while that result waits.
// If the receiver stalls, the result holds steady; a following result waits
// in the sequencer until the output register is free.
// Reset (synchronous, active low) zeroes position, target and velocity and
// loads the default acceleration and speed limit. Configuration writes
// through i_cfg_we / i_cfg_idx / i_cfg_data take effect at once and belong
// to idle periods.
// ----------------------------------------------------------------------------
module inertial_motion_profile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  imp_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output imp_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [imp_pkg::CfgWidth-1:0]  i_cfg_data
);

    // Command and status bundles between the sequencer and the datapath.
    imp_pkg::t_dp_cmd  w_cmd;
    imp_pkg::t_dp_stat w_stat;

    // The sequencer walks a tick through the multiplier schedule and holds
    // the output valid flag.
    imp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the motion state, the configuration registers,
    // the shared multiplier and the output register.
    imp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

>>> rtl/imp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imp_checker: port checks of the inertial motion profile
// Watches the handshakes and the beat ordering seen at the top-level ports.
// ----------------------------------------------------------------------------
module imp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  imp_pkg::t_out_beat            o_out_data
);

    // An accepted beat keeps the input closed while it is worked on.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    // A new result appears only as the sequencer finishes a beat.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a beat in progress");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output beat changed while stalled");

endmodule

bind inertial_motion_profile imp_checker u_imp_checker (.*);

>>> test/tb_inertial_motion_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inertial_motion_profile: self-checking bench for the motion profile
// The bench drives command beats through the valid/stall channel. A bit-exact
// Q16.16 profile predictor inside a scoreboard class forecasts every output
// beat, and each accepted output beat is compared with the oldest forecast.
// The run visits default, full-scale, minimum, zero and random settings.
// ----------------------------------------------------------------------------
module tb_inertial_motion_profile;
    import imp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [CfgWidth-1:0] CFG_FULL = 31'h7FFF_FFFF;
    localparam logic signed [31:0] POS_TOP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_BOTTOM = 32'sh8000_0000;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Scoreboard: it carries its own copy of the profile state and settings,
    // forecasts the output beat of every accepted command beat, and checks
    // the output beats in order against those forecasts.
    class motion_scoreboard;
        longint unsigned accel_setting;
        longint unsigned speed_limit;
        longint pos_q;
        longint target_q;
        longint vel_q;
        t_out_beat expected_beats[$];
        int unsigned mismatches;
        int unsigned beats_checked;
        int unsigned cmd_counts[4];
        int unsigned arrivals;

        function new();
            accel_setting = ACCEL_RESET;
            speed_limit = MAX_SPEED_RESET;
            pos_q = 0;
            target_q = 0;
            vel_q = 0;
            mismatches = 0;
            beats_checked = 0;
            arrivals = 0;
            foreach (cmd_counts[i]) cmd_counts[i] = 0;
        endfunction

        function void set_register(logic idx, logic [CfgWidth-1:0] data);
            if (idx == CFG_ACCEL) begin
                accel_setting = data;
            end else begin
                speed_limit = data;
            end
        endfunction

        function longint unsigned magnitude(longint x);
            return (x < 0) ? longint'(-x) : longint'(x);
        endfunction

        // Apply a signed direction to a magnitude; direction 0 gives 0.
        function longint with_sign(int dir, longint unsigned m);
            if (dir < 0) return -longint'(m);
            if (dir > 0) return longint'(m);
            return 0;
        endfunction

        // One tick of the trapezoidal profile over dt seconds (Q0.16).
        function void advance_profile(logic [15:0] dt);
            int dir;
            int acc_dir;
            longint unsigned dt64;
            longint unsigned gap;
            longint unsigned vmag;
            longint unsigned nmag;
            longint nv;
            longint np;

            if (pos_q == target_q) return;
            dt64 = dt;
            dir = (pos_q < target_q) ? 1 : -1;
            acc_dir = dir;
            gap = magnitude(pos_q - target_q);
            vmag = magnitude(vel_q);

            // Brake when heading toward the target inside stopping distance.
            if (((vel_q > 0 && dir > 0) || (vel_q < 0 && dir < 0)) &&
                accel_setting * gap <= ((vmag * vmag) >> 1)) begin
                acc_dir = -dir;
            end

            nv = vel_q + with_sign(acc_dir, (dt64 * accel_setting) >> 16);
            if ((nv < 0 && vel_q > 0) || (nv > 0 && vel_q < 0)) nv = 0;
            nmag = magnitude(nv);
            if (nmag >= speed_limit) begin
                nv = with_sign((nv < 0) ? -1 : ((nv > 0) ? 1 : 0), speed_limit);
            end
            nmag = magnitude(nv);

            np = pos_q + with_sign((nv < 0) ? -1 : 1, (nmag * dt64) >> 16)
                 + with_sign(acc_dir, ((dt64 * dt64) * accel_setting) >> 33);
            if (np > POS_MAX) np = POS_MAX;
            if (np < POS_MIN) np = POS_MIN;

            if (magnitude(np - target_q) <= ((nmag * dt64) >> 17)) begin
                np = target_q;
                nv = 0;
            end
            if (np == target_q) arrivals++;
            pos_q = np;
            vel_q = nv;
        endfunction

        function void note_command(t_in_beat b);
            t_out_beat want;

            cmd_counts[b.cmd]++;
            case (b.cmd)
                CMD_TICK: begin
                    advance_profile(b.dt);
                end
                CMD_SET: begin
                    target_q = longint'($signed(b.value));
                end
                CMD_JUMP: begin
                    pos_q = longint'($signed(b.value));
                    target_q = pos_q;
                    vel_q = 0;
                end
                default: begin
                end
            endcase
            want.position = pos_q[31:0];
            want.velocity = vel_q[31:0];
            want.at_target = (pos_q == target_q);
            expected_beats.push_back(want);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat want;

            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected output beat: position %0d velocity %0d at_target %0b",
                             $signed(got.position), $signed(got.velocity), got.at_target);
                end
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (got.position !== want.position || got.velocity !== want.velocity ||
                got.at_target !== want.at_target) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("beat %0d: position exp %0d got %0d, velocity exp %0d got %0d",
                             beats_checked, $signed(want.position), $signed(got.position),
                             $signed(want.velocity), $signed(got.velocity));
                    $display("beat %0d: at_target exp %0b got %0b",
                             beats_checked, want.at_target, got.at_target);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_beat             in_data;
    logic                 out_valid;
    logic                 out_stall;
    t_out_beat            out_data;
    logic                 cfg_we;
    logic                 cfg_idx;
    logic [CfgWidth-1:0]  cfg_data;

    // When set, neither side idles: a stretch of back-to-back beats.
    bit                   quiet;
    int unsigned          cycle_count;
    int unsigned          settings_used;
    motion_scoreboard     sb;

    inertial_motion_profile DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. A run that stalls or loses beats ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Both channels are observed at the rising edge. An input beat is noted
    // before the output beat of the same edge is checked; a command beat can
    // never produce its own result in the cycle it is taken.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_command(in_data);
            if (out_valid && !out_stall) sb.check_beat(out_data);
        end
    end

    // The receiver stalls in about one cycle out of five unless quiet.
    always @(negedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 19);
    end

    // Present one command beat and hold it until it is taken. Idle cycles
    // are inserted ahead of the beat; valid is lowered and raised on
    // different falling edges, so it never glitches within a time step.
    task automatic send_beat(input logic [1:0] cmd, input logic [15:0] dt,
                             input logic signed [31:0] value);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 19) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.cmd <= cmd;
        in_data.dt <= dt;
        in_data.value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold off the sender until every forecast beat has been checked, then
    // let the pipeline settle. Configuration writes only follow this.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(input logic idx, input logic [CfgWidth-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_profile(input logic [CfgWidth-1:0] accel,
                                   input logic [CfgWidth-1:0] speed);
        program_register(CFG_ACCEL, accel);
        program_register(CFG_MAX_SPEED, speed);
        settings_used++;
    endtask

    // Mostly long ticks, with zero, full-scale and arbitrary lengths mixed in.
    function automatic logic [15:0] random_dt();
        int unsigned pick;

        pick = $urandom_range(99);
        if (pick < 5) return 16'd0;
        if (pick < 10) return 16'hFFFF;
        if (pick < 20) return 16'($urandom);
        return 16'($urandom_range(16384, 65535));
    endfunction

    // Either anywhere in the Q16.16 range or within 256.0 of 0.
    function automatic logic signed [31:0] random_position();
        if ($urandom_range(1)) return $signed($urandom);
        return $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
    endfunction

    // A target a few seconds of acceleration away, kept inside the range.
    function automatic logic signed [31:0] reachable_target(logic signed [31:0] from);
        longint offset;
        longint goal;

        offset = longint'(sb.accel_setting) * $urandom_range(1, 12) + $urandom_range(0, 65535);
        if ($urandom_range(1)) offset = -offset;
        goal = longint'(from) + offset;
        if (goal > POS_MAX) goal = POS_MAX;
        if (goal < POS_MIN) goal = POS_MIN;
        return goal[31:0];
    endfunction

    // Random traffic. Four picks in five start a move sequence: a jump,
    // a reachable target and a run of ticks, sometimes retargeted midway.
    // The rest are single arbitrary beats, the unused command code included.
    task automatic run_random(input int unsigned beats);
        int unsigned sent;
        int unsigned ticks;
        logic signed [31:0] start;

        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(99) < 80) begin
                start = random_position();
                send_beat(CMD_JUMP, 16'($urandom), start);
                send_beat(CMD_SET, 16'($urandom), reachable_target(start));
                ticks = $urandom_range(4, 16);
                sent += 2 + ticks;
                repeat (ticks) begin
                    if ($urandom_range(99) < 6) begin
                        send_beat(CMD_SET, 16'($urandom), reachable_target(start));
                        sent++;
                    end
                    send_beat(CMD_TICK, random_dt(), $signed($urandom));
                end
            end else begin
                send_beat(2'($urandom_range(3)), 16'($urandom), random_position());
                sent++;
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ACCEL;
        cfg_data = '0;
        quiet = 1'b0;
        cycle_count = 0;
        settings_used = 1;
        sb = new();

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings. A tick at the target leaves
        // everything alone, and the unused code only reports the state.
        send_beat(CMD_TICK, 16'hFFFF, 32'sd0);
        send_beat(CMD_UNUSED, 16'h5555, 32'shAAAA_AAAA);
        // Accelerate toward 10.0, brake, and see a zero-length tick.
        send_beat(CMD_SET, 16'hAAAA, 32'sd655360);
        repeat (6) send_beat(CMD_TICK, 16'hFFFF, 32'sh5555_5555);
        send_beat(CMD_TICK, 16'h0000, 32'sd0);
        // Retarget behind the motion, so the velocity must not reverse.
        send_beat(CMD_SET, 16'h0000, -32'sd655360);
        repeat (3) send_beat(CMD_TICK, 16'hFFFF, 32'sd0);

        // With no acceleration the velocity holds; with a zero speed limit
        // every tick leaves the velocity at zero.
        drain_pipeline();
        program_register(CFG_ACCEL, '0);
        repeat (2) send_beat(CMD_TICK, 16'h8000, 32'sd0);
        drain_pipeline();
        program_register(CFG_MAX_SPEED, '0);
        send_beat(CMD_TICK, 16'hFFFF, 32'sd0);
        drain_pipeline();
        program_profile(ACCEL_RESET, MAX_SPEED_RESET);

        // Jumps to both ends of the position range and moves across it.
        send_beat(CMD_JUMP, 16'h0000, POS_TOP);
        send_beat(CMD_SET, 16'hFFFF, POS_BOTTOM);
        send_beat(CMD_TICK, 16'hFFFF, 32'sd0);
        send_beat(CMD_JUMP, 16'hFFFF, POS_BOTTOM);
        send_beat(CMD_SET, 16'h0000, POS_TOP);
        send_beat(CMD_TICK, 16'hFFFF, 32'sd0);
        send_beat(CMD_JUMP, 16'h1234, 32'sh5555_5555);
        send_beat(CMD_TICK, 16'h4321, 32'sd0);

        // Random phases, each under its own settings.
        for (int phase = 0; phase < 6; phase++) begin
            drain_pipeline();
            case (phase)
                0: program_profile(CFG_FULL, CFG_FULL);
                1: program_profile(31'd1, 31'd1);
                2: program_profile('0, '0);
                default: program_profile(31'($urandom_range(32'h1000, 32'h40_0000)),
                                         31'($urandom_range(32'h1000, 32'h0200_0000)));
            endcase
            quiet = (phase == 3);
            run_random((phase == 2) ? 20 : 85);
        end
        quiet = 1'b0;

        drain_pipeline();
        $display("Covered %0d ticks, %0d set-target, %0d jump and %0d unused-code beats.",
                 sb.cmd_counts[CMD_TICK], sb.cmd_counts[CMD_SET],
                 sb.cmd_counts[CMD_JUMP], sb.cmd_counts[CMD_UNUSED]);
        $display("%0d output beats checked, %0d ticks ended on target, %0d settings used.",
                 sb.beats_checked, sb.arrivals, settings_used);
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/imp_pkg.sv
rtl/imp_ctrl.sv
rtl/imp_dpath.sv
rtl/inertial_motion_profile.sv
rtl/imp_checker.sv
test/tb_inertial_motion_profile.sv
